>>> hw/rtl/babystep_pulse_burst_generator_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the step and direction pulse generator
// concurrent checks that compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef BABYSTEP_PULSE_BURST_GENERATOR_ASSERT_SVH
`define BABYSTEP_PULSE_BURST_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSPBG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSPBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BSPBG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BSPBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bspbg_pkg.sv
// ---------------------------------------------------------------------------
// bspbg_pkg
// types and constants shared by the step and direction pulse generator
// ---------------------------------------------------------------------------
`default_nettype none

package bspbg_pkg;

  localparam int OP_W       = 2;
  localparam int COUNT_W    = 16;
  localparam int STEPS_W    = 17;
  localparam int TIMER_W    = 20;
  localparam int PULSE_W    = 20;
  localparam int SETUP_W    = 16;
  localparam int GAP_W      = 20;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_BURST  = 2'd1;
  localparam logic [OP_W-1:0] OP_SINGLE = 2'd2;

  // sequencer phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SETUP = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PULSE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_GAP   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_POL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 3'd4;

  // register reset values
  localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 20'd100;
  localparam logic [SETUP_W-1:0] LEAD_TICKS_RST  = 16'd72;
  localparam logic [GAP_W-1:0]   GAP_TICKS_RST   = 20'd18000;

  // 2^16, base for the magnitude of a negative count
  localparam logic [STEPS_W-1:0] NEG_BASE = 17'h10000;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [COUNT_W-1:0] step_count;
    logic                      direction;
  } item_t;

  typedef struct packed {
    logic dir_level;
    logic step_level;
    logic busy_res;
    logic accepted;
  } res_t;

  typedef struct packed {
    logic               enabled;
    logic               step_pol;
    logic [PULSE_W-1:0] pulse_ticks;
    logic [SETUP_W-1:0] lead_ticks;
    logic [GAP_W-1:0]   gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [STEPS_W-1:0] steps_left;
    logic               gap_wanted;
  } seq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bspbg_if.sv
// ---------------------------------------------------------------------------
// bspbg channel interfaces
// valid/ready channels for items, results and register writes
// ---------------------------------------------------------------------------
`default_nettype none

interface bspbg_in_if;
  import bspbg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COUNT_W-1:0] step_count;
  logic                      direction;
  modport source (output valid, output operation, output step_count, output direction,
                  input ready);
  modport sink (input valid, input operation, input step_count, input direction,
                output ready);
endinterface

interface bspbg_out_if;
  logic valid;
  logic ready;
  logic dir_level;
  logic step_level;
  logic busy_res;
  logic accepted;
  modport source (output valid, output dir_level, output step_level, output busy_res,
                  output accepted, input ready);
  modport sink (input valid, input dir_level, input step_level, input busy_res,
                input accepted, output ready);
endinterface

interface bspbg_cfg_if;
  import bspbg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bspbg_seq.sv
// ---------------------------------------------------------------------------
// bspbg_seq
// step sequencer: phase, timer and step count, one item per go strobe
// ---------------------------------------------------------------------------
`default_nettype none

module bspbg_seq (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    go,
  input  bspbg_pkg::item_t       item,
  input  bspbg_pkg::cfg_t        cfg,
  output bspbg_pkg::res_t        res,
  output bspbg_pkg::seq_stat_t   stat
);
  import bspbg_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [STEPS_W-1:0] steps_left_r, steps_left_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               dir_out_r, dir_out_nxt;
  logic               gap_wanted_r, gap_wanted_nxt;
  logic               acc;

  logic               timer_end;
  logic [TIMER_W-1:0] timer_step;
  logic               can_start;
  logic               neg;
  logic [STEPS_W-1:0] raw_ext;
  logic [STEPS_W-1:0] mag;
  logic [TIMER_W-1:0] setup_load;

  assign timer_end  = (timer_r[TIMER_W-1:1] == '0);
  assign timer_step = timer_end ? '0 : timer_r - TIMER_W'(1);
  assign can_start  = cfg.enabled && (phase_r == PH_IDLE);
  assign neg        = item.step_count[COUNT_W-1];
  assign raw_ext    = {1'b0, item.step_count};
  // most negative count comes out as 2^15 steps
  assign mag        = neg ? (NEG_BASE - raw_ext) : raw_ext;
  assign setup_load = TIMER_W'(cfg.lead_ticks);

  always_comb begin
    phase_nxt      = phase_r;
    steps_left_nxt = steps_left_r;
    timer_nxt      = timer_r;
    dir_out_nxt    = dir_out_r;
    gap_wanted_nxt = gap_wanted_r;
    acc            = 1'b0;
    case (item.operation)
      OP_TICK: begin
        case (phase_r)
          PH_SETUP: begin
            timer_nxt = timer_step;
            if (timer_end) begin
              phase_nxt = PH_PULSE;
              timer_nxt = cfg.pulse_ticks;
            end
          end
          PH_PULSE: begin
            timer_nxt = timer_step;
            if (timer_end) begin
              steps_left_nxt = steps_left_r - STEPS_W'(1);
              if (gap_wanted_r) begin
                phase_nxt = PH_GAP;
                timer_nxt = cfg.gap_ticks;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_GAP: begin
            timer_nxt = timer_step;
            if (timer_end) begin
              if (steps_left_r != '0) begin
                phase_nxt = PH_SETUP;
                timer_nxt = setup_load;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      OP_BURST: begin
        if (can_start) begin
          acc = 1'b1;
          if (mag != '0) begin
            dir_out_nxt    = item.direction ^ neg;
            steps_left_nxt = mag;
            gap_wanted_nxt = 1'b1;
            phase_nxt      = PH_SETUP;
            timer_nxt      = setup_load;
          end
        end
      end
      OP_SINGLE: begin
        if (can_start) begin
          acc            = 1'b1;
          dir_out_nxt    = item.direction;
          steps_left_nxt = STEPS_W'(1);
          gap_wanted_nxt = 1'b0;
          phase_nxt      = PH_SETUP;
          timer_nxt      = setup_load;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      steps_left_r <= '0;
      timer_r      <= '0;
      dir_out_r    <= 1'b0;
      gap_wanted_r <= 1'b0;
    end else if (go) begin
      phase_r      <= phase_nxt;
      steps_left_r <= steps_left_nxt;
      timer_r      <= timer_nxt;
      dir_out_r    <= dir_out_nxt;
      gap_wanted_r <= gap_wanted_nxt;
    end
  end

  // result shows the state after the item
  always_comb begin
    res.dir_level  = dir_out_nxt;
    res.step_level = (phase_nxt == PH_PULSE) ^ cfg.step_pol;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.accepted   = acc;
  end

  assign stat.phase      = phase_r;
  assign stat.steps_left = steps_left_r;
  assign stat.gap_wanted = gap_wanted_r;

endmodule

`default_nettype wire

>>> hw/rtl/babystep_pulse_burst_generator.sv
// ---------------------------------------------------------------------------
// babystep_pulse_burst_generator
// step and direction pulse generator driven by tick and command items
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: a tick (operation 0), a burst
//   command (1, signed step_count, base direction) or a single step (2).
//   out_ch returns exactly one result per item: direction level, step level
//   after polarity, busy flag and whether the command was taken.
//   cfg_ch writes one register per transfer (0 enabled, 1 step polarity,
//   2 pulse ticks, 3 setup lead ticks, 4 gap ticks); it is always ready and
//   is meant to be used while no item is in flight.
//   An item lands in the input register at its transfer edge; the
//   sequencer update moves it on into the result register once that
//   register is free or leaving, and out_ch presents it from there.
//   Throughput is one item per cycle while the receiver does not stall;
//   the sequencer state updates in the same cycle an item moves into
//   the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ch.ready drops once both are occupied.
//   Synchronous reset returns the sequencer to idle with no steps left and
//   loads the register defaults (disabled, 100 pulse, 72 setup, 18000 gap).
// ---------------------------------------------------------------------------
`default_nettype none

`include "babystep_pulse_burst_generator_assert.svh"

module babystep_pulse_burst_generator (
  input wire          clk,
  input wire          rst_n,
  bspbg_in_if.sink    in_ch,
  bspbg_out_if.source out_ch,
  bspbg_cfg_if.sink   cfg_ch
);
  import bspbg_pkg::*;

  cfg_t      cfg_r;
  item_t     s1_item_r;
  logic      s1_valid_r;
  res_t      out_res_r;
  logic      out_valid_r;
  res_t      seq_res;
  seq_stat_t seq_stat;
  logic      s1_adv;
  logic      in_xfer;
  logic      cfg_xfer;

  // the input register drains whenever the result register is free or leaving
  assign s1_adv   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled     <= 1'b0;
      cfg_r.step_pol    <= 1'b0;
      cfg_r.pulse_ticks <= PULSE_TICKS_RST;
      cfg_r.lead_ticks  <= LEAD_TICKS_RST;
      cfg_r.gap_ticks   <= GAP_TICKS_RST;
    end else if (cfg_xfer) begin
      case (cfg_ch.idx)
        CFG_ENABLED:     cfg_r.enabled     <= cfg_ch.data[0];
        CFG_STEP_POL:    cfg_r.step_pol    <= cfg_ch.data[0];
        CFG_PULSE_TICKS: cfg_r.pulse_ticks <= cfg_ch.data[PULSE_W-1:0];
        CFG_LEAD_TICKS:  cfg_r.lead_ticks  <= cfg_ch.data[SETUP_W-1:0];
        CFG_GAP_TICKS:   cfg_r.gap_ticks   <= cfg_ch.data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.operation  <= in_ch.operation;
      s1_item_r.step_count <= in_ch.step_count;
      s1_item_r.direction  <= in_ch.direction;
    end
  end

  bspbg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_valid_r && s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (seq_res),
    .stat  (seq_stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_res_r <= seq_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dir_level  = out_res_r.dir_level;
  assign out_ch.step_level = out_res_r.step_level;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.accepted   = out_res_r.accepted;

  `BSPBG_ASSERT_IMPL(a_idle_no_steps, clk, rst_n, seq_stat.phase == PH_IDLE, seq_stat.steps_left == '0, "idle with steps left")
  `BSPBG_ASSERT_IMPL(a_gap_in_burst, clk, rst_n, seq_stat.phase == PH_GAP, seq_stat.gap_wanted, "gap phase outside a burst")
  `BSPBG_ASSERT_IMPL(a_steps_bound, clk, rst_n, 1'b1, seq_stat.steps_left <= NEG_BASE, "step count above burst maximum")
  `BSPBG_ASSERT_NEXT(a_tick_not_taken, clk, rst_n, s1_valid_r && s1_adv && s1_item_r.operation == OP_TICK, !out_res_r.accepted, "tick reported as taken command")

endmodule

`default_nettype wire
